// ===== rtl/core/spa_pkg.sv =====
// Shared types and constants for the slot pool allocator.
package spa_pkg;

    localparam int IDX_W     = 6;
    localparam int WDATA_W   = 32;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } spa_ctrl_t;

endpackage

// ===== rtl/core/spa_if.sv =====
// Command and result channel interfaces of the slot pool allocator.
interface spa_cmd_if
    import spa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [IDX_W-1:0]   slot_index;
    logic [WDATA_W-1:0] write_data;

    modport source (output valid, cmd, slot_index, write_data, input ready);
    modport sink   (input valid, cmd, slot_index, write_data, output ready);
endinterface

interface spa_res_if
    import spa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     result_slot;
    logic [WDATA_W-1:0]   read_data;
    logic                 hit;
    logic                 pool_full;
    logic [CNT_OUT_W-1:0] live_objects;
    logic [CNT_OUT_W-1:0] slots_used;

    modport source (output valid, result_slot, read_data, hit, pool_full, live_objects,
                    slots_used, input ready);
    modport sink   (input valid, result_slot, read_data, hit, pool_full, live_objects,
                    slots_used, output ready);
endinterface

// ===== rtl/core/spa_ctrl.sv =====
// Sequencing state machine of the slot pool allocator.
module spa_ctrl
    import spa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output spa_ctrl_t ctl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // a new beat may enter as the finished one leaves
    assign in_ready    = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_ready);
    assign out_valid   = (state_reg == ST_DONE);
    assign ctl.capture = in_valid && in_ready;
    assign ctl.execute = (state_reg == ST_EXEC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.capture)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                priority if (ctl.capture)
                    state_next = ST_EXEC;
                else if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/spa_datapath.sv =====
// Valid bitmap, first-free search, counters and slot store.
module spa_datapath
    import spa_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  spa_ctrl_t            ctl,
    input  logic [1:0]           cmd,
    input  logic [IDX_W-1:0]     slot_index,
    input  logic [WDATA_W-1:0]   write_data,
    output logic [IDX_W-1:0]     result_slot,
    output logic [WDATA_W-1:0]   read_data,
    output logic                 hit,
    output logic                 pool_full,
    output logic [CNT_OUT_W-1:0] live_objects,
    output logic [CNT_OUT_W-1:0] slots_used
);

    // Only slots below 64 can be addressed, so only they can ever be freed
    // or read; slots above are counted but hold no bit and no data.
    localparam int VW     = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);
    localparam int MW     = $clog2(VW);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SW     = (DATA_WIDTH < WDATA_W) ? DATA_WIDTH : WDATA_W;

    cmd_t             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [SW-1:0]    wdata_reg;

    logic [VW-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0] hw_reg, hw_next;
    logic [CNT_W-1:0] live_reg, live_next;

    logic [IDX_W-1:0] rslot_reg, rslot_next;
    logic             hit_reg, hit_next;
    logic             full_reg, full_next;
    logic             rden_reg, rden_next;

    logic [SW-1:0]    mem [VW];
    logic [SW-1:0]    mem_q;

    logic [VW-1:0]    free;
    logic             found_low;
    logic [MW-1:0]    low_idx;
    logic             in_range;
    logic [MW-1:0]    idx_m;
    logic             slot_hit;
    logic             hw_room;
    logic [CNT_W-1:0] target;
    logic             add_ok;
    logic             tgt_in_mem;
    logic [MW-1:0]    tgt_m;
    logic             mem_we;

    // lowest clear bit below the high-water mark
    always_comb
    begin
        for (int i = 0; i < VW; i++)
            free[i] = !valid_reg[i] && (CNT_W'(i) < hw_reg);
        found_low = 1'b0;
        low_idx   = '0;
        for (int i = VW - 1; i >= 0; i--)
        begin
            if (free[i])
            begin
                found_low = 1'b1;
                low_idx   = MW'(i);
            end
        end
    end

    assign in_range   = ({1'b0, idx_reg} < (IDX_W + 1)'(VW));
    assign idx_m      = idx_reg[MW-1:0];
    assign slot_hit   = in_range && valid_reg[idx_m];
    assign hw_room    = (hw_reg < CNT_W'(CAPACITY));
    assign target     = found_low ? CNT_W'(low_idx) : hw_reg;
    assign add_ok     = found_low || hw_room;
    assign tgt_in_mem = (target < CNT_W'(VW));
    assign tgt_m      = target[MW-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        hw_next    = hw_reg;
        live_next  = live_reg;
        rslot_next = rslot_reg;
        hit_next   = hit_reg;
        full_next  = full_reg;
        rden_next  = rden_reg;
        mem_we     = 1'b0;
        if (ctl.execute)
        begin
            rslot_next = idx_reg;
            hit_next   = 1'b0;
            full_next  = 1'b0;
            rden_next  = 1'b0;
            unique case (cmd_reg)
                CMD_ADD:
                begin
                    if (add_ok)
                    begin
                        if (tgt_in_mem)
                        begin
                            valid_next[tgt_m] = 1'b1;
                            mem_we            = 1'b1;
                        end
                        if (!found_low)
                            hw_next = hw_reg + CNT_W'(1);
                        live_next  = live_reg + CNT_W'(1);
                        rslot_next = IDX_W'(target);
                        hit_next   = 1'b1;
                    end
                    else
                    begin
                        rslot_next = '0;
                        full_next  = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (slot_hit)
                    begin
                        valid_next[idx_m] = 1'b0;
                        live_next         = live_reg - CNT_W'(1);
                    end
                end
                CMD_READ:
                begin
                    hit_next  = slot_hit;
                    rden_next = slot_hit;
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hw_reg    <= '0;
            live_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hw_reg    <= hw_next;
            live_reg  <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd_t'(cmd);
            idx_reg   <= slot_index;
            wdata_reg <= write_data[SW-1:0];
        end
        rslot_reg <= rslot_next;
        hit_reg   <= hit_next;
        full_reg  <= full_next;
        rden_reg  <= rden_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tgt_m] <= wdata_reg;
        if (ctl.execute)
            mem_q <= mem[idx_m];
    end

    assign result_slot  = rslot_reg;
    assign read_data    = rden_reg ? WDATA_W'(mem_q) : '0;
    assign hit          = hit_reg;
    assign pool_full    = full_reg;
    assign live_objects = CNT_OUT_W'(live_reg);
    assign slots_used   = CNT_OUT_W'(hw_reg);

endmodule

// ===== rtl/core/slot_pool_allocator_unit.sv =====
// Slot pool allocator top level: controller, datapath and checks.
// A command beat is captured into the command registers, executed in the execute
// state, and its registered result beat is presented in the done state.
// A new command is not taken while one executes; a new beat can be taken in the cycle
// the previous result leaves, and a stalled result beat holds off new commands. The
// first-free priority search and registered slot-store read share the execute state.
// Reset: asynchronous, active low; clears valid marks and both counters at once.
module slot_pool_allocator_unit
    import spa_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input logic       clk,
    input logic       rst_n,
    spa_cmd_if.sink   req,
    spa_res_if.source rsp
);

    spa_ctrl_t ctl;

    spa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    spa_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd          (req.cmd),
        .slot_index   (req.slot_index),
        .write_data   (req.write_data),
        .result_slot  (rsp.result_slot),
        .read_data    (rsp.read_data),
        .hit          (rsp.hit),
        .pool_full    (rsp.pool_full),
        .live_objects (rsp.live_objects),
        .slots_used   (rsp.slots_used)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("command taken while result beat is stalled");

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !rsp.valid ##1 rsp.valid)
        else $error("result beat not presented two cycles after command");

    a_hit_excl_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.pool_full))
        else $error("hit and pool_full both set");

    a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.pool_full) |-> (rsp.slots_used == CNT_OUT_W'(CAPACITY)))
        else $error("add refused below capacity");

endmodule
